### design/kwm_pkg.sv
package kwm_pkg;

    // Result status codes.
    localparam logic [1:0] STAT_VALUE  = 2'd0;
    localparam logic [1:0] STAT_FINISH = 2'd1;
    localparam logic [1:0] STAT_DROP   = 2'd2;

    typedef struct packed {
        logic [2:0]         lane;
        logic signed [31:0] value;
        logic               list_end;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] merged_value;
        logic [2:0]         source_lane;
    } t_out_word;

    // Control of the shared minimum unit.
    typedef struct packed {
        logic clear;
        logic take;
    } t_scan_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } t_state;

endpackage

### design/kwm_head_mem.sv
module kwm_head_mem #(
    parameter int LANES = 8
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(LANES)-1:0]         i_waddr,
    input  logic signed [31:0]               i_wdata,
    input  logic [$clog2(LANES)-1:0]         i_raddr,
    output logic signed [31:0]               o_rdata
);
    import kwm_pkg::*;

    logic signed [31:0] r_mem [LANES];
    logic signed [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/kwm_min_unit.sv
module kwm_min_unit #(
    parameter int LANES = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  kwm_pkg::t_scan_ctl       i_ctl,
    input  logic signed [31:0]       i_data,
    input  logic [$clog2(LANES)-1:0] i_lane,
    output logic signed [31:0]       o_best_value,
    output logic [$clog2(LANES)-1:0] o_best_lane
);
    import kwm_pkg::*;

    localparam int LW = $clog2(LANES);

    logic              r_have;
    logic signed [31:0] r_best_value;
    logic [LW-1:0]     r_best_lane;
    logic              win;

    // Strictly smaller wins, so with an ascending scan ties stay with the lower lane.
    assign win = i_ctl.take && (!r_have || (i_data < r_best_value));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_ctl.clear) begin
            r_have <= 1'b0;
        end else if (win) begin
            r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (win) begin
            r_best_value <= i_data;
            r_best_lane  <= i_lane;
        end
    end

    assign o_best_value = r_best_value;
    assign o_best_lane  = r_best_lane;

endmodule

### design/k_way_sorted_merge.sv
// K-way sorted merge of up to LANES ascending streams of signed 32-bit words.
// Input channel (i_in_valid, o_in_stall, i_in_word): each word carries the next
// element of one lane, or marks that lane's stream as ended. A word is taken at
// a clock edge where i_in_valid is high and o_in_stall is low.
// Output channel (o_out_valid, i_out_stall, o_out_word): each result word carries
// an emitted value with its source lane, a merge-finished mark, or a drop report
// for an input word that hit a full, ended or inactive lane.
// Configuration channel (i_cfg_valid, o_cfg_ready, i_cfg_data) writes the number
// of active lanes and abandons any merge in progress. An input word offered in
// the same cycle as a write is held off until the write has been taken.
// Steps: a word that releases a value passes check, scan, drain and emit; the
// scan is set by the one comparator that walks the head memory one lane per cycle.
// A word that leaves some lane waiting passes check only, a dropped word goes
// to emit, a finishing word passes check and emit, before the next acceptance.
// A result is registered; it appears the cycle after the emit step and the
// block takes the next input word while it waits.
// If the receiver stalls, the result word holds, and a following result waits
// in the emit step until the output register frees.
// Reset (synchronous, active low) empties all head slots, clears the ended
// marks and sets the active lane count to 8. No clearing pass is needed.
module k_way_sorted_merge #(
    parameter int LANES = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  kwm_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output kwm_pkg::t_out_word  o_out_word,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [3:0]          i_cfg_data
);
    import kwm_pkg::*;

    localparam int LW  = $clog2(LANES);
    localparam int CW0 = $clog2(LANES + 1);
    localparam int CW  = (CW0 > 4) ? CW0 : 4;

    t_state             r_state, n_state;
    logic [3:0]         r_lanes;
    logic [LANES-1:0]   r_full, n_full;
    logic [LANES-1:0]   r_fin, n_fin;
    logic [LW-1:0]      r_ptr;
    logic               r_tk;
    logic [LW-1:0]      r_tk_lane;
    logic [1:0]         r_res_status;
    logic [2:0]         r_res_lane;
    logic               r_out_valid;
    t_out_word          r_out_word;

    logic [CW-1:0]      lanes_ext;
    logic [CW-1:0]      n_act;
    logic [CW-1:0]      ln_ext;
    logic [LW-1:0]      idx;
    logic [LANES-1:0]   act;
    logic [LANES-1:0]   unfin;
    logic               all_done;
    logic               all_ready;
    logic               accept;
    logic               cfg_we;
    logic               drop;
    logic               scan_last;
    logic               out_load;
    logic               mem_we;
    logic signed [31:0] mem_rdata;
    logic signed [31:0] best_value;
    logic [LW-1:0]      best_lane;
    logic [LW+2:0]      best_lane_ext;
    t_scan_ctl          scan_ctl;
    t_out_word          res_word;

    // Active lane count: zero acts as one, anything above LANES acts as LANES.
    assign lanes_ext = CW'(r_lanes);
    assign n_act = (r_lanes == 4'd0) ? CW'(1) :
                   ((lanes_ext > CW'(LANES)) ? CW'(LANES) : lanes_ext);

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            act[i] = (CW'(i) < n_act);
        end
    end

    assign unfin     = act & ~r_fin;
    assign all_done  = (unfin == '0);
    assign all_ready = ((unfin & ~r_full) == '0);

    assign ln_ext = CW'(i_in_word.lane);
    assign idx    = ln_ext[LW-1:0];
    // The flag lookups only count when the lane lies inside the active range.
    assign drop   = (ln_ext >= n_act) || r_fin[idx] || r_full[idx];

    assign accept    = i_in_valid && !o_in_stall;
    assign cfg_we    = i_cfg_valid && o_cfg_ready;
    assign mem_we    = accept && !drop && !i_in_word.list_end;
    assign scan_last = (CW'(r_ptr) == (n_act - CW'(1)));
    assign out_load  = !r_out_valid || !i_out_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = drop ? ST_EMIT : ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (all_done) begin
                    n_state = ST_EMIT;
                end else if (!all_ready) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Handshake and unit control, decoded from the state.
    always_comb begin
        o_in_stall     = 1'b1;
        o_cfg_ready    = 1'b0;
        scan_ctl.clear = 1'b0;
        // The take flag lines up with the registered read of the head memory.
        scan_ctl.take  = r_tk;
        case (r_state)
            ST_IDLE: begin
                // A pending register write goes first.
                o_in_stall  = i_cfg_valid;
                o_cfg_ready = 1'b1;
            end
            ST_CHECK: begin
                scan_ctl.clear = 1'b1;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // Head slot and ended flags.
    always_comb begin
        n_full = r_full;
        n_fin  = r_fin;
        if (cfg_we) begin
            n_full = '0;
            n_fin  = '0;
        end else if (accept && !drop) begin
            if (i_in_word.list_end) begin
                n_fin[idx] = 1'b1;
            end else begin
                n_full[idx] = 1'b1;
            end
        end else if ((r_state == ST_CHECK) && all_done) begin
            n_full = '0;
            n_fin  = '0;
        end else if ((r_state == ST_EMIT) && out_load && (r_res_status == STAT_VALUE)) begin
            n_full[best_lane] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_lanes     <= 4'd8;
            r_full      <= '0;
            r_fin       <= '0;
            r_tk        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_full  <= n_full;
            r_fin   <= n_fin;
            r_tk    <= (r_state == ST_SCAN) && unfin[r_ptr];
            if (cfg_we) begin
                r_lanes <= i_cfg_data;
            end
            if ((r_state == ST_EMIT) && out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Scan pointer and the pending result's status.
    always_ff @(posedge i_clk) begin
        r_tk_lane <= r_ptr;
        if (r_state == ST_CHECK) begin
            r_ptr <= '0;
        end else if (r_state == ST_SCAN) begin
            r_ptr <= r_ptr + LW'(1);
        end
        if (accept) begin
            r_res_status <= drop ? STAT_DROP : STAT_VALUE;
            r_res_lane   <= i_in_word.lane;
        end else if ((r_state == ST_CHECK) && all_done) begin
            r_res_status <= STAT_FINISH;
        end
        if ((r_state == ST_EMIT) && out_load) begin
            r_out_word <= res_word;
        end
    end

    assign best_lane_ext = (LW + 3)'(best_lane);

    always_comb begin
        res_word.status       = r_res_status;
        res_word.merged_value = '0;
        res_word.source_lane  = '0;
        case (r_res_status)
            STAT_VALUE: begin
                res_word.merged_value = best_value;
                res_word.source_lane  = best_lane_ext[2:0];
            end
            STAT_DROP: begin
                res_word.source_lane = r_res_lane;
            end
            default: begin
                res_word.source_lane = '0;
            end
        endcase
    end

    kwm_head_mem #(
        .LANES (LANES)
    ) u_head_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (idx),
        .i_wdata (i_in_word.value),
        .i_raddr (r_ptr),
        .o_rdata (mem_rdata)
    );

    kwm_min_unit #(
        .LANES (LANES)
    ) u_min_unit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (scan_ctl),
        .i_data       (mem_rdata),
        .i_lane       (r_tk_lane),
        .o_best_value (best_value),
        .o_best_lane  (best_lane)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

### design/kwm_checker.sv
module kwm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input kwm_pkg::t_in_word  i_in_word,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input kwm_pkg::t_out_word o_out_word,
    input logic               i_cfg_valid,
    input logic               o_cfg_ready,
    input logic [3:0]         i_cfg_data
);
    import kwm_pkg::*;

    // A configuration write and an input word are never taken in the same cycle.
    a_cfg_vs_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cfg_valid && o_cfg_ready && i_in_valid && !o_in_stall))
        else $error("config write and input word taken together");

    // One word at a time: an accepted word closes the input for the next cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input open right after an accepted word");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.status == STAT_VALUE ||
                         o_out_word.status == STAT_FINISH ||
                         o_out_word.status == STAT_DROP))
        else $error("unknown status code");

    a_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.status != STAT_VALUE)) |->
            (o_out_word.merged_value == '0))
        else $error("value carried on a non-value result");

endmodule

bind k_way_sorted_merge kwm_checker u_kwm_checker (.*);
